FILE: rtl/core/sma_crossover_signal_macros.svh
// Assertion macros for the moving average crossover block.
`ifndef SMA_CROSSOVER_SIGNAL_MACROS_SVH
`define SMA_CROSSOVER_SIGNAL_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SMAC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/smac_pkg.sv
package smac_pkg;

	// Configuration register width and reset values
	localparam int REG_W = 9;
	localparam logic [REG_W-1:0] SHORT_RST = 9'd5;
	localparam logic [REG_W-1:0] LONG_RST  = 9'd20;

	// Widths of the fixed stream fields
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 32;

	// Register index as decoded from paddr[2]
	typedef enum logic {
		REG_SHORT = 1'b0,
		REG_LONG  = 1'b1
	} reg_idx_t;

	// Trading signal codes
	typedef enum logic [1:0] {
		SIG_HOLD = 2'd0,
		SIG_BUY  = 2'd1,
		SIG_SELL = 2'd2
	} signal_t;

	// Relation of short average to long average
	typedef enum logic [1:0] {
		REL_NONE    = 2'd0,
		REL_LESS    = 2'd1,
		REL_EQUAL   = 2'd2,
		REL_GREATER = 2'd3
	} relation_t;

endpackage

FILE: rtl/core/sma_crossover_signal.sv
// Dual simple moving average crossover detector. Each request carries one
// Q16.16 price (s_tdata) and a new-series flag (s_tuser) and yields exactly one
// result, presented on m_tvalid after stage 1, stage 2, stage 3 and the output
// register: signal and averages-valid flag on m_tuser, sample index and price
// on m_tdata. One sample is taken every cycle while not stalled; the price ring
// is a MAX_WINDOW-deep memory with one write port and two registered read
// ports (short and long window tails), read and written at the accepting edge.
// Rolling sums update one stage later, the two cross products are registered
// in the next stage, and the compare with the stored relation feeds the output
// register. Stalls on m_tready back up stage by stage, so bubbles still let
// new requests in. Any configuration write restarts the series, and must be
// done with no request in flight.
`include "sma_crossover_signal_macros.svh"

module sma_crossover_signal #(
	parameter int MAX_WINDOW = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] price
	input  logic        s_tuser,   // [0] new_series
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] sample_index, [63:32] price_out
	output logic [2:0]  m_tuser,   // [1:0] signal, [2] averages_valid
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW    = (PRICE_BITS < smac_pkg::FIELD_W) ? PRICE_BITS : smac_pkg::FIELD_W;
	localparam int WW    = $clog2(MAX_WINDOW + 1);
	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int SUM_W = PW + WW;
	localparam int PROD_W = SUM_W + WW;
	localparam int RW    = smac_pkg::REG_W;
	localparam int CW    = smac_pkg::COUNT_W;

	// Configuration registers
	logic [RW-1:0] short_reg_q, long_reg_q;
	logic          cfg_wr;
	logic [WW-1:0] ws_eff, wl_eff, need;

	// Series state
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        wp_q;
	logic [SUM_W-1:0]     sum_s_q, sum_l_q;
	smac_pkg::relation_t  prev_rel_q;

	// Ring memory
	logic [PW-1:0] ring_mem [MAX_WINDOW];

	// Accept-side values
	logic          acc;
	logic [PW-1:0] price_in;
	logic [CW-1:0] idx_in, seen_in;
	logic [AW-1:0] wp_in, addr_s, addr_l;
	logic [AW:0]   dist_s, dist_l, pext, back_s, back_l;
	logic          valid_in;

	// Stage 1
	logic          v_s1, new_s1, sub_s_s1, sub_l_s1, valid_s1;
	logic [PW-1:0] price_s1, rd_s_s1, rd_l_s1;
	logic [CW-1:0] idx_s1;

	// Stage 2 (sums live in sum_s_q / sum_l_q)
	logic          v_s2, new_s2, valid_s2;
	logic [PW-1:0] price_s2;
	logic [CW-1:0] idx_s2;

	// Stage 3
	logic              v_s3, new_s3, valid_s3;
	logic [PW-1:0]     price_s3;
	logic [CW-1:0]     idx_s3;
	logic [PROD_W-1:0] prod_a_s3, prod_b_s3;

	// Output register
	logic                  out_v_q, out_valid_q;
	smac_pkg::signal_t     out_sig_q;
	logic [CW-1:0]         out_idx_q;
	logic [PW-1:0]         out_price_q;

	// Flow control
	logic rdy_o, rdy_s3, rdy_s2, rdy_s1, mv_s1, mv_s2, mv_s3;

	// Combinational results
	logic [SUM_W-1:0]    sum_s_nxt, sum_l_nxt;
	smac_pkg::relation_t rel_cur, rel_prev;
	smac_pkg::signal_t   sig_cur;

	// Clamp window registers to 1..MAX_WINDOW
	always_comb begin
		if (short_reg_q == '0) begin
			ws_eff = WW'(1);
		end else if (32'(short_reg_q) > 32'(MAX_WINDOW)) begin
			ws_eff = WW'(MAX_WINDOW);
		end else begin
			ws_eff = WW'(short_reg_q);
		end
		if (long_reg_q == '0) begin
			wl_eff = WW'(1);
		end else if (32'(long_reg_q) > 32'(MAX_WINDOW)) begin
			wl_eff = WW'(MAX_WINDOW);
		end else begin
			wl_eff = WW'(long_reg_q);
		end
		need = (ws_eff > wl_eff) ? ws_eff : wl_eff;
	end

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		case (smac_pkg::reg_idx_t'(paddr[2]))
			smac_pkg::REG_SHORT: prdata = 32'(short_reg_q);
			smac_pkg::REG_LONG:  prdata = 32'(long_reg_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_reg_q <= smac_pkg::SHORT_RST;
			long_reg_q  <= smac_pkg::LONG_RST;
		end else if (cfg_wr) begin
			case (smac_pkg::reg_idx_t'(paddr[2]))
				smac_pkg::REG_SHORT: short_reg_q <= pwdata[RW-1:0];
				smac_pkg::REG_LONG:  long_reg_q  <= pwdata[RW-1:0];
				default:             short_reg_q <= short_reg_q;
			endcase
		end
	end

	// Backpressure chain, one stage at a time
	assign rdy_o    = !out_v_q || m_tready;
	assign rdy_s3   = !v_s3 || rdy_o;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign mv_s3    = v_s3 && rdy_o;
	assign mv_s2    = v_s2 && rdy_s3;
	assign mv_s1    = v_s1 && rdy_s2;
	assign s_tready = rdy_s1;
	assign acc      = s_tvalid && rdy_s1;

	// Accept: restart, index, ring tail addresses
	always_comb begin
		price_in = s_tdata[PW-1:0];
		idx_in   = s_tuser ? '0 : count_q;
		wp_in    = s_tuser ? '0 : wp_q;
		seen_in  = (idx_in == '1) ? idx_in : idx_in + CW'(1);
		valid_in = (idx_in == '1) || (seen_in >= CW'(need));
		pext     = {1'b0, wp_in};
		dist_s   = (AW+1)'(ws_eff);
		dist_l   = (AW+1)'(wl_eff);
		back_s   = (pext >= dist_s) ? pext - dist_s : pext + (AW+1)'(MAX_WINDOW) - dist_s;
		back_l   = (pext >= dist_l) ? pext - dist_l : pext + (AW+1)'(MAX_WINDOW) - dist_l;
		addr_s   = back_s[AW-1:0];
		addr_l   = back_l[AW-1:0];
	end

	// Ring memory: read old tails and write the new price at the same edge
	always_ff @(posedge clk) begin
		if (acc) begin
			ring_mem[wp_in] <= price_in;
			rd_s_s1         <= ring_mem[addr_s];
			rd_l_s1         <= ring_mem[addr_l];
		end
	end

	// Roll the window sums
	always_comb begin
		sum_s_nxt = (new_s1 ? '0 : sum_s_q) + SUM_W'(price_s1)
			- (sub_s_s1 ? SUM_W'(rd_s_s1) : '0);
		sum_l_nxt = (new_s1 ? '0 : sum_l_q) + SUM_W'(price_s1)
			- (sub_l_s1 ? SUM_W'(rd_l_s1) : '0);
	end

	// Compare cross products and detect the cross
	always_comb begin
		rel_prev = new_s3 ? smac_pkg::REL_NONE : prev_rel_q;
		if (!valid_s3) begin
			rel_cur = smac_pkg::REL_NONE;
		end else if (prod_a_s3 < prod_b_s3) begin
			rel_cur = smac_pkg::REL_LESS;
		end else if (prod_a_s3 == prod_b_s3) begin
			rel_cur = smac_pkg::REL_EQUAL;
		end else begin
			rel_cur = smac_pkg::REL_GREATER;
		end
		sig_cur = smac_pkg::SIG_HOLD;
		if (ws_eff < wl_eff && rel_cur != smac_pkg::REL_NONE
				&& rel_prev != smac_pkg::REL_NONE) begin
			if (rel_prev != smac_pkg::REL_GREATER && rel_cur == smac_pkg::REL_GREATER) begin
				sig_cur = smac_pkg::SIG_BUY;
			end else if (rel_prev != smac_pkg::REL_LESS && rel_cur == smac_pkg::REL_LESS) begin
				sig_cur = smac_pkg::SIG_SELL;
			end
		end
	end

	// Series state: count, pointer, sums, relation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			wp_q       <= '0;
			sum_s_q    <= '0;
			sum_l_q    <= '0;
			prev_rel_q <= smac_pkg::REL_NONE;
		end else if (cfg_wr) begin
			count_q    <= '0;
			wp_q       <= '0;
			sum_s_q    <= '0;
			sum_l_q    <= '0;
			prev_rel_q <= smac_pkg::REL_NONE;
		end else begin
			if (acc) begin
				count_q <= seen_in;
				wp_q    <= (32'(wp_in) == MAX_WINDOW - 1) ? '0 : wp_in + AW'(1);
			end
			if (mv_s1) begin
				sum_s_q <= sum_s_nxt;
				sum_l_q <= sum_l_nxt;
			end
			if (mv_s3) begin
				prev_rel_q <= rel_cur;
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1    <= acc;
			if (rdy_s2) v_s2    <= v_s1;
			if (rdy_s3) v_s3    <= v_s2;
			if (rdy_o)  out_v_q <= v_s3;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (acc) begin
			price_s1 <= price_in;
			idx_s1   <= idx_in;
			new_s1   <= s_tuser;
			sub_s_s1 <= idx_in >= CW'(ws_eff);
			sub_l_s1 <= idx_in >= CW'(wl_eff);
			valid_s1 <= valid_in;
		end
		if (mv_s1) begin
			price_s2 <= price_s1;
			idx_s2   <= idx_s1;
			new_s2   <= new_s1;
			valid_s2 <= valid_s1;
		end
		if (mv_s2) begin
			price_s3  <= price_s2;
			idx_s3    <= idx_s2;
			new_s3    <= new_s2;
			valid_s3  <= valid_s2;
			prod_a_s3 <= PROD_W'(sum_s_q) * PROD_W'(wl_eff);
			prod_b_s3 <= PROD_W'(sum_l_q) * PROD_W'(ws_eff);
		end
		if (mv_s3) begin
			out_sig_q   <= sig_cur;
			out_idx_q   <= idx_s3;
			out_price_q <= price_s3;
			out_valid_q <= valid_s3;
		end
	end

	// Result stream
	assign m_tvalid = out_v_q;
	assign m_tdata  = {smac_pkg::FIELD_W'(out_price_q), out_idx_q};
	assign m_tuser  = {out_valid_q, out_sig_q};

	// Checks
	`SMAC_ASSERT_IMPL(a_hold_until_valid, m_tvalid && !m_tuser[2], m_tuser[1:0] == smac_pkg::SIG_HOLD, "cross signaled before averages valid")
	`SMAC_ASSERT_IMPL(a_hold_bad_windows, m_tvalid && ws_eff >= wl_eff, m_tuser[1:0] == smac_pkg::SIG_HOLD, "cross signaled with short window not below long")
	`SMAC_ASSERT_NEXT(a_cfg_restart, cfg_wr, count_q == '0 && wp_q == '0 && prev_rel_q == smac_pkg::REL_NONE, "configuration write did not restart series")

endmodule

FILE: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = 256;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_WAIT    = 18;
	localparam int PIPE_DRAIN  = 8;

	typedef struct {
		logic [31:0] price;
		logic        fresh;
	} price_sample_t;

	typedef struct {
		smac_pkg::signal_t sig;
		logic [31:0]       index;
		logic [31:0]       price;
		logic              avg_valid;
	} crossover_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] price
	logic        s_tuser = 1'b0; // [0] new_series
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] sample_index, [63:32] price_out
	logic [2:0]  m_tuser;        // [1:0] signal, [2] averages_valid
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sma_crossover_signal uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	price_sample_t     pending_samples[$];
	crossover_result_t expected_signals[$];
	int                mismatch_count = 0;

	// Shadow of the block's registers and series state
	logic [8:0]          fast_reg = smac_pkg::SHORT_RST;
	logic [8:0]          slow_reg = smac_pkg::LONG_RST;
	logic [31:0]         price_ring [RING_DEPTH];
	logic [40:0]         fast_sum = '0;
	logic [40:0]         slow_sum = '0;
	logic [31:0]         series_count = '0;
	logic [7:0]          ring_ptr = '0;
	smac_pkg::relation_t last_rel = smac_pkg::REL_NONE;

	// Handshake bookkeeping shared between the edges
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int   in_gap = 0;
	int   out_stall = 0;
	bit   in_calm = 1'b0;
	bit   out_calm = 1'b0;
	int   quiet_cycles = 0;

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Occasionally switch between gapped traffic and back-to-back stretches
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [8:0] window_len(logic [8:0] raw);
		if (raw == 0)
			return 9'd1;
		if (raw > RING_DEPTH)
			return 9'(RING_DEPTH);
		return raw;
	endfunction

	function automatic void restart_series();
		fast_sum = '0;
		slow_sum = '0;
		series_count = '0;
		ring_ptr = '0;
		last_rel = smac_pkg::REL_NONE;
	endfunction

	// Roll both window sums, compare cross products and derive the signal
	function automatic void predict_crossover(logic [31:0] px, logic fresh);
		logic [8:0]          ws;
		logic [8:0]          wl;
		logic [8:0]          need;
		logic [7:0]          tail;
		logic [31:0]         idx;
		logic [31:0]         seen;
		logic                valid;
		logic [49:0]         lhs;
		logic [49:0]         rhs;
		smac_pkg::relation_t rel;
		crossover_result_t   res;
		ws = window_len(fast_reg);
		wl = window_len(slow_reg);
		need = (ws > wl) ? ws : wl;
		if (fresh)
			restart_series();
		idx = series_count;
		fast_sum = fast_sum + px;
		if (idx >= ws) begin
			tail = ring_ptr - ws[7:0];
			fast_sum = fast_sum - price_ring[tail];
		end
		slow_sum = slow_sum + px;
		if (idx >= wl) begin
			tail = ring_ptr - wl[7:0];
			slow_sum = slow_sum - price_ring[tail];
		end
		price_ring[ring_ptr] = px;
		ring_ptr = ring_ptr + 8'd1;
		seen = (idx == '1) ? idx : idx + 32'd1;
		valid = (idx == '1) || (seen >= need);
		series_count = seen;
		rel = smac_pkg::REL_NONE;
		if (valid) begin
			lhs = fast_sum * wl;
			rhs = slow_sum * ws;
			if (lhs < rhs)
				rel = smac_pkg::REL_LESS;
			else if (lhs == rhs)
				rel = smac_pkg::REL_EQUAL;
			else
				rel = smac_pkg::REL_GREATER;
		end
		res.sig = smac_pkg::SIG_HOLD;
		if (ws < wl && rel != smac_pkg::REL_NONE && last_rel != smac_pkg::REL_NONE) begin
			if (last_rel != smac_pkg::REL_GREATER && rel == smac_pkg::REL_GREATER)
				res.sig = smac_pkg::SIG_BUY;
			else if (last_rel != smac_pkg::REL_LESS && rel == smac_pkg::REL_LESS)
				res.sig = smac_pkg::SIG_SELL;
		end
		last_rel = rel;
		res.index = idx;
		res.price = px;
		res.avg_valid = valid;
		expected_signals = {expected_signals, res};
	endfunction

	// Sample at the rising edge: register access, requests, results, watchdog
	always @(posedge clk) begin
		crossover_result_t want;
		logic [8:0]        reg_val;
		if (arst_n) begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (smac_pkg::reg_idx_t'(paddr[2]))
						smac_pkg::REG_SHORT: fast_reg = pwdata[8:0];
						smac_pkg::REG_LONG:  slow_reg = pwdata[8:0];
						default:             ;
					endcase
					restart_series();
				end else begin
					reg_val = (smac_pkg::reg_idx_t'(paddr[2]) == smac_pkg::REG_SHORT)
						? fast_reg : slow_reg;
					if (prdata[8:0] !== reg_val)
						report_mismatch($sformatf("register %0d read %h want %h",
							paddr[2], prdata[8:0], reg_val));
				end
			end
			if (s_tvalid && s_tready)
				predict_crossover(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (expected_signals.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = expected_signals.pop_front();
					if (m_tuser[1:0] !== want.sig)
						report_mismatch($sformatf("sample %0d signal %0d want %0d",
							want.index, m_tuser[1:0], want.sig));
					if (m_tuser[2] !== want.avg_valid)
						report_mismatch($sformatf("sample %0d valid %b want %b",
							want.index, m_tuser[2], want.avg_valid));
					if (m_tdata[31:0] !== want.index)
						report_mismatch($sformatf("sample index %h want %h",
							m_tdata[31:0], want.index));
					if (m_tdata[63:32] !== want.price)
						report_mismatch($sformatf("sample %0d price %h want %h",
							want.index, m_tdata[63:32], want.price));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL sma_crossover_signal");
				$finish;
			end
		end
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
	end

	// Request driver: hold until accepted, then idle for the drawn gap
	always @(negedge clk) begin
		price_sample_t item;
		if (arst_n && !(s_tvalid && !in_taken)) begin
			if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap--;
			end else if (pending_samples.size() > 0) begin
				item = pending_samples.pop_front();
				s_tdata <= item.price;
				s_tuser <= item.fresh;
				s_tvalid <= 1'b1;
				in_gap = draw_wait(in_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: stall for a drawn number of cycles after each result
	always @(negedge clk) begin
		if (out_taken)
			out_stall = draw_wait(out_calm);
		if (out_stall > 0) begin
			m_tready <= 1'b0;
			out_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic queue_sample(logic [31:0] px, logic fresh);
		price_sample_t item;
		item.price = px;
		item.fresh = fresh;
		pending_samples = {pending_samples, item};
	endtask

	// Wait until every request is in and every result is out
	task automatic drain_all();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_signals.size() != 0);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_window(smac_pkg::reg_idx_t which, logic [8:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {which, 2'b00};
		pwdata <= {23'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_window(smac_pkg::reg_idx_t which);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {which, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Set both windows and read them back, then stream trending prices with flat runs and noise
	task automatic run_phase(logic [8:0] fast, logic [8:0] slow, int count, int restart_odds);
		logic [31:0] level;
		logic [31:0] px;
		int          drift;
		int          run_left;
		bit          flat;
		logic        fresh;
		write_window(smac_pkg::REG_SHORT, fast);
		write_window(smac_pkg::REG_LONG, slow);
		read_window(smac_pkg::REG_SHORT);
		read_window(smac_pkg::REG_LONG);
		level = $urandom;
		run_left = 0;
		drift = 0;
		flat = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				flat = ($urandom_range(0, 4) == 0);
				drift = int'($urandom_range(0, 4000)) - 2000;
				run_left = $urandom_range(3, 40);
			end
			run_left--;
			if ($urandom_range(0, 99) < 6) begin
				px = $urandom;
			end else begin
				if (!flat)
					level = level + drift + $urandom_range(0, 600) - 300;
				px = level;
			end
			fresh = (restart_odds != 0) && ($urandom_range(0, restart_odds - 1) == 0);
			queue_sample(px, fresh);
		end
		drain_all();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Field extremes at the reset windows
		queue_sample(32'hFFFF_FFFF, 1'b1);
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h7FFF_FFFF, 1'b1);
		drain_all();

		// Crosses from equal, less and greater with the shortest windows
		write_window(smac_pkg::REG_SHORT, 9'd1);
		write_window(smac_pkg::REG_LONG, 9'd2);
		queue_sample(32'd100, 1'b1);
		queue_sample(32'd100, 1'b0);
		queue_sample(32'd200, 1'b0);
		queue_sample(32'd200, 1'b0);
		queue_sample(32'd100, 1'b0);
		queue_sample(32'd300, 1'b0);
		queue_sample(32'd100, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b0);
		queue_sample(32'd0, 1'b0);
		queue_sample(32'd0, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b0);
		queue_sample(32'd7, 1'b1);
		queue_sample(32'd8, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h7FFF_FFFF, 1'b0);
		queue_sample(32'h7FFF_FFFF, 1'b0);
		drain_all();

		// Random phases over default, zero, equal, inverted and saturated windows
		run_phase(9'd5, 9'd20, 60, 40);
		run_phase(9'd0, 9'd7, 50, 30);
		run_phase(9'd3, 9'd3, 25, 20);
		run_phase(9'd9, 9'd4, 30, 20);
		run_phase(9'd511, 9'd0, 20, 10);
		run_phase(9'd1, 9'd2, 40, 15);
		run_phase(9'd256, 9'd257, 10, 0);
		run_phase(9'd6, 9'd300, 280, 0);

		if (mismatch_count == 0)
			$display("PASS sma_crossover_signal");
		else
			$display("FAIL sma_crossover_signal");
		$finish;
	end

endmodule
